/* rtl/alrb_pkg.sv */
// Package for the remove-before list: widths, result codes, controller states and control structs.
package alrb_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int STATUS_W     = 3;
	localparam int COUNT_W      = 5;
	localparam int POS_W        = 4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_NO_PRED   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEARCH_RD,
		S_SEARCH_CMP,
		S_SHIFT_CHK,
		S_SHIFT_WR
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    rd;
		logic    append;
		logic    shift_wr;
		logic    inc_ptr;
		logic    save_pos;
		logic    dec_count;
		logic    finish;
		logic    take_pos;
		status_t code;
	} cmd_t;

	// Conditions reported by the datapath to the controller.
	typedef struct packed {
		logic op;
		logic empty;
		logic full;
		logic match;
		logic ptr_zero;
		logic ptr_last;
		logic ptr_end;
	} flags_t;

endpackage

/* rtl/alrb_ctrl.sv */
// Controller state machine for the remove-before list.
module alrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  alrb_pkg::flags_t  flags,
	output logic              busy,
	output alrb_pkg::cmd_t    cmd
);

	alrb_pkg::state_t state_q;
	alrb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alrb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != alrb_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.code = alrb_pkg::ST_OK;
		unique case (state_q)
			alrb_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = alrb_pkg::S_DISPATCH;
				end
			end
			alrb_pkg::S_DISPATCH: begin
				if (!flags.op) begin
					cmd.finish = 1'b1;
					state_d    = alrb_pkg::S_IDLE;
					if (flags.full) begin
						cmd.code = alrb_pkg::ST_FULL;
					end else begin
						cmd.append = 1'b1;
						cmd.code   = alrb_pkg::ST_OK;
					end
				end else if (flags.empty) begin
					cmd.finish = 1'b1;
					cmd.code   = alrb_pkg::ST_EMPTY;
					state_d    = alrb_pkg::S_IDLE;
				end else begin
					state_d = alrb_pkg::S_SEARCH_RD;
				end
			end
			alrb_pkg::S_SEARCH_RD: begin
				cmd.rd  = 1'b1;
				state_d = alrb_pkg::S_SEARCH_CMP;
			end
			alrb_pkg::S_SEARCH_CMP: begin
				if (flags.match) begin
					if (flags.ptr_zero) begin
						cmd.finish = 1'b1;
						cmd.code   = alrb_pkg::ST_NO_PRED;
						state_d    = alrb_pkg::S_IDLE;
					end else begin
						// The matching entry is already read; it is the first to move down.
						cmd.save_pos = 1'b1;
						cmd.shift_wr = 1'b1;
						cmd.inc_ptr  = 1'b1;
						state_d      = alrb_pkg::S_SHIFT_CHK;
					end
				end else if (flags.ptr_last) begin
					cmd.finish = 1'b1;
					cmd.code   = alrb_pkg::ST_NOT_FOUND;
					state_d    = alrb_pkg::S_IDLE;
				end else begin
					cmd.inc_ptr = 1'b1;
					state_d     = alrb_pkg::S_SEARCH_RD;
				end
			end
			alrb_pkg::S_SHIFT_CHK: begin
				if (flags.ptr_end) begin
					cmd.dec_count = 1'b1;
					cmd.finish    = 1'b1;
					cmd.take_pos  = 1'b1;
					cmd.code      = alrb_pkg::ST_OK;
					state_d       = alrb_pkg::S_IDLE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = alrb_pkg::S_SHIFT_WR;
				end
			end
			alrb_pkg::S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.inc_ptr  = 1'b1;
				state_d      = alrb_pkg::S_SHIFT_CHK;
			end
			default: begin
				state_d = alrb_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/alrb_dp.sv */
// Datapath for the remove-before list: entry memory, count, walk pointer and result registers.
module alrb_dp #(
	parameter int CAPACITY = alrb_pkg::CAPACITY_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  operation,
	input  logic signed [alrb_pkg::VALUE_W-1:0]   value,
	input  alrb_pkg::cmd_t                        cmd,
	output alrb_pkg::flags_t                      flags,
	output logic                                  done,
	output logic [alrb_pkg::STATUS_W-1:0]         status,
	output logic [alrb_pkg::COUNT_W-1:0]          entry_count,
	output logic [alrb_pkg::POS_W-1:0]            found_position
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [alrb_pkg::VALUE_W-1:0] mem [CAPACITY];

	logic                          op_q;
	logic [alrb_pkg::VALUE_W-1:0]  val_q;
	logic [alrb_pkg::VALUE_W-1:0]  rdata_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 ptr_q;
	logic [AW-1:0]                 pos_q;
	logic                          done_q;
	alrb_pkg::status_t             status_q;
	logic [AW-1:0]                 res_pos_q;

	logic [AW-1:0] wr_addr;
	logic [CW-1:0] ptr_dec;
	logic [CW:0]   ptr_inc;

	assign ptr_dec = ptr_q - CW'(1);
	assign ptr_inc = {1'b0, ptr_q} + (CW+1)'(1);
	assign wr_addr = cmd.append ? count_q[AW-1:0] : ptr_dec[AW-1:0];

	// Single write port and single registered read port.
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[wr_addr] <= val_q;
		end else if (cmd.shift_wr) begin
			mem[wr_addr] <= rdata_q;
		end
		if (cmd.rd) begin
			rdata_q <= mem[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= operation;
			val_q <= value;
		end
		if (cmd.save_pos) begin
			pos_q <= ptr_q[AW-1:0];
		end
		if (cmd.finish) begin
			status_q  <= cmd.code;
			res_pos_q <= cmd.take_pos ? pos_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.dec_count) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.inc_ptr) begin
				ptr_q <= ptr_inc[CW-1:0];
			end
		end
	end

	assign flags.op       = op_q;
	assign flags.empty    = (count_q == '0);
	assign flags.full     = (count_q == CW'(CAPACITY));
	assign flags.match    = (rdata_q == val_q);
	assign flags.ptr_zero = (ptr_q == '0);
	assign flags.ptr_last = (ptr_inc == {1'b0, count_q});
	assign flags.ptr_end  = (ptr_q == count_q);

	assign done           = done_q;
	assign status         = status_q;
	assign entry_count    = alrb_pkg::COUNT_W'(count_q);
	assign found_position = alrb_pkg::POS_W'(res_pos_q);

endmodule

/* rtl/array_list_remove_before.sv */
// Top level of the unordered list with append and remove-before-reference.
// An append, or a remove on an empty list, finishes in the dispatch state.
// A remove walks the memory one entry at a time through its single read port, searching
// and then moving later entries down.
// One item at a time: busy is high until the result beat; the receiver cannot stall.
// Reset clears the entry count and the controller; memory contents are left as they are.
module array_list_remove_before #(
	parameter int CAPACITY = alrb_pkg::CAPACITY_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  operation,
	input  logic signed [alrb_pkg::VALUE_W-1:0]   value,
	output logic                                  done,
	output logic [alrb_pkg::STATUS_W-1:0]         status,
	output logic [alrb_pkg::COUNT_W-1:0]          entry_count,
	output logic [alrb_pkg::POS_W-1:0]            found_position
);

	// The controller sequences each beat; the datapath owns all storage and comparisons.
	alrb_pkg::cmd_t   cmd;
	alrb_pkg::flags_t flags;

	alrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.busy   (busy),
		.cmd    (cmd)
	);

	// The result registers sit in the datapath, so a new start can be taken in the
	// same cycle as the done beat of the previous item.
	alrb_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.operation      (operation),
		.value          (value),
		.cmd            (cmd),
		.flags          (flags),
		.done           (done),
		.status         (status),
		.entry_count    (entry_count),
		.found_position (found_position)
	);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the remove-before list: directed and random operations checked beat by beat.
module testbench;

	localparam int CAP = alrb_pkg::CAPACITY_DEF;

	// Operation codes carried on the operation port.
	localparam logic OP_APPEND        = 1'b0;
	localparam logic OP_REMOVE_BEFORE = 1'b1;

	// A remove walks the store once, searching and then shifting, so a drained block
	// settles within SETTLE_CYCLES. The stall limit is far beyond the longest
	// legal wait: the longest sender gap plus the longest remove.
	localparam int SETTLE_CYCLES = 2 * CAP + 10;
	localparam int STALL_LIMIT   = 2000;

	// What one operation must report on its result beat.
	typedef struct packed {
		alrb_pkg::status_t              status;
		logic [alrb_pkg::COUNT_W-1:0]   count;
		logic [alrb_pkg::POS_W-1:0]     pos;
	} list_outcome_t;

	logic                                  clk;
	logic                                  arst_n = 1'b0;
	logic                                  start = 1'b0;
	logic                                  operation = OP_APPEND;
	logic signed [alrb_pkg::VALUE_W-1:0]   value = '0;
	logic                                  busy;
	logic                                  done;
	logic [alrb_pkg::STATUS_W-1:0]         status;
	logic [alrb_pkg::COUNT_W-1:0]          entry_count;
	logic [alrb_pkg::POS_W-1:0]            found_position;

	// Behavioral copy of the list, in order, and the outcomes still owed by the block.
	logic signed [alrb_pkg::VALUE_W-1:0]   held_vals[$];
	list_outcome_t                         pending_outcomes[$];

	int error_count = 0;
	int stall_cycles = 0;
	bit idle_enable = 1'b1;

	array_list_remove_before #(
		.CAPACITY(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value(value),
		.done(done),
		.status(status),
		.entry_count(entry_count),
		.found_position(found_position)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one operation to the behavioral list and returns the outcome the block
	// must report. An append on a full list and every failed remove leave the list as
	// it is; a successful remove drops the entry just ahead of the first match.
	function automatic list_outcome_t apply_list_op(logic op,
			logic signed [alrb_pkg::VALUE_W-1:0] v);
		list_outcome_t r;
		int hit;
		int i;
		r.status = alrb_pkg::ST_OK;
		r.pos = '0;
		hit = -1;
		if (op == OP_APPEND) begin
			if (held_vals.size() >= CAP)
				r.status = alrb_pkg::ST_FULL;
			else
				held_vals.push_back(v);
		end else if (held_vals.size() == 0) begin
			r.status = alrb_pkg::ST_EMPTY;
		end else begin
			for (i = 0; i < held_vals.size() && hit < 0; i++)
				if (held_vals[i] == v)
					hit = i;
			if (hit < 0)
				r.status = alrb_pkg::ST_NOT_FOUND;
			else if (hit == 0)
				r.status = alrb_pkg::ST_NO_PRED;
			else begin
				held_vals.delete(hit - 1);
				r.pos = hit[alrb_pkg::POS_W-1:0];
			end
		end
		r.count = alrb_pkg::COUNT_W'(held_vals.size());
		return r;
	endfunction

	// True when the behavioral list holds the given value anywhere.
	function automatic bit is_held(logic signed [alrb_pkg::VALUE_W-1:0] v);
		foreach (held_vals[i])
			if (held_vals[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// Sends one command beat. Start is left high on return, so a following call
	// without a gap keeps it high instead of toggling it within one time step. The
	// outcome is predicted at the edge that accepts the beat, which keeps the
	// behavioral list in step with the stimulus that reads it.
	task automatic issue_op(logic op, logic signed [alrb_pkg::VALUE_W-1:0] v);
		int gap;
		if (idle_enable && $urandom_range(99) < 37) begin
			// Mostly short gaps, sometimes long ones that outlast a whole remove.
			gap = ($urandom_range(3) != 0) ? $urandom_range(4, 1) : $urandom_range(40, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		value <= v;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(apply_list_op(op, v));
	endtask

	// Drops start and holds off until every owed result beat has come back.
	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	function automatic void check_field(string name, logic [31:0] expd, logic [31:0] actual);
		if (actual !== expd) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expd, actual);
			error_count++;
		end
	endfunction

	// Every result beat is matched against the oldest owed outcome. The block
	// cannot be stalled, so done is simply sampled at each edge.
	always @(posedge clk) begin : check_results
		list_outcome_t exp_out;
		if (done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result beat with nothing pending: status %0d count %0d pos %0d",
					$time, status, entry_count, found_position);
				error_count++;
			end else begin
				exp_out = pending_outcomes.pop_front();
				check_field("status", 32'(exp_out.status), 32'(status));
				check_field("entry_count", 32'(exp_out.count), 32'(entry_count));
				check_field("found_position", 32'(exp_out.pos), 32'(found_position));
			end
		end
	end

	// Ends a hung run: any accepted command or result beat restarts the count.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// A remove on a freshly reset list must report empty.
	task automatic test_remove_on_empty();
		issue_op(OP_REMOVE_BEFORE, 32'sh7fff_ffff);
	endtask

	// Fills the list with the value extremes and alternating bit patterns, tops it
	// up with random values, then tries one append too many.
	task automatic test_fill_to_full();
		issue_op(OP_APPEND, 32'sh8000_0000);
		issue_op(OP_APPEND, 32'sh7fff_ffff);
		issue_op(OP_APPEND, 32'sh0000_0000);
		issue_op(OP_APPEND, -32'sd1);
		issue_op(OP_APPEND, 32'sh0000_0001);
		issue_op(OP_APPEND, 32'sh5555_5555);
		issue_op(OP_APPEND, 32'shaaaa_aaaa);
		while (held_vals.size() < CAP)
			issue_op(OP_APPEND, $urandom);
		issue_op(OP_APPEND, 32'sh1234_5678);
	endtask

	// Covers the not-found and no-predecessor removes and the successful ones at the far end and
	// against a duplicated value, where only the first match counts.
	task automatic test_remove_cases();
		logic signed [alrb_pkg::VALUE_W-1:0] absent;
		do absent = $urandom; while (is_held(absent));
		issue_op(OP_REMOVE_BEFORE, absent);
		issue_op(OP_REMOVE_BEFORE, held_vals[0]);
		issue_op(OP_REMOVE_BEFORE, held_vals[CAP - 1]);
		issue_op(OP_APPEND, held_vals[3]);
		issue_op(OP_REMOVE_BEFORE, held_vals[3]);
	endtask

	// Random operations as a walk of the fill level between empty and full. Most
	// removes name a held value so they get past the search; the rest name small
	// values, which also repeat often, or arbitrary ones that are usually absent.
	task automatic test_random_ops(int n_ops, bit with_idle);
		logic op;
		logic signed [alrb_pkg::VALUE_W-1:0] v;
		int pick;
		idle_enable = with_idle;
		repeat (n_ops) begin
			if (held_vals.size() == 0)
				op = ($urandom_range(99) < 80) ? OP_APPEND : OP_REMOVE_BEFORE;
			else if (held_vals.size() >= CAP)
				op = ($urandom_range(99) < 80) ? OP_REMOVE_BEFORE : OP_APPEND;
			else
				op = $urandom_range(1) ? OP_REMOVE_BEFORE : OP_APPEND;
			pick = $urandom_range(99);
			if (op == OP_REMOVE_BEFORE && held_vals.size() != 0 && pick < 60)
				v = held_vals[$urandom_range(held_vals.size() - 1)];
			else if (pick < 80)
				v = $urandom_range(7);
			else
				v = $urandom;
			issue_op(op, v);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_remove_on_empty();
		test_fill_to_full();
		test_remove_cases();
		// The sender holds off here until the block has answered everything.
		wait_for_results();

		test_random_ops(350, 1'b1);
		// A long stretch with the sender never idling.
		test_random_ops(250, 1'b0);
		wait_for_results();
		test_random_ops(350, 1'b1);

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* array_list_remove_before.f */
rtl/alrb_pkg.sv
rtl/alrb_ctrl.sv
rtl/alrb_dp.sv
rtl/array_list_remove_before.sv
tb/sv/testbench.sv
